// ----- sv/mmq_pkg.sv -----
// ----------------------------------------------------------------------------
// mmq_pkg
// Shared codes and control types of the min/max int8 quantizer.
// ----------------------------------------------------------------------------
package mmq_pkg;

   // request type codes
   localparam logic REQ_OBSERVE  = 1'b0;
   localparam logic REQ_QUANTIZE = 1'b1;

   // result kind codes
   localparam logic KIND_SCALE = 1'b0;
   localparam logic KIND_CODE  = 1'b1;

   // quotient bits for a code: enough to see anything above 128
   localparam int QUANT_QUOT_BITS = 9;

   // saturation limits of the int8 code, as quotient magnitudes
   localparam logic [QUANT_QUOT_BITS-1:0] CODE_POS_LIMIT = 9'd127;
   localparam logic [QUANT_QUOT_BITS-1:0] CODE_NEG_LIMIT = 9'd128;

   // full-range span of the int8 code
   localparam logic [7:0] RANGE_DIVISOR = 8'd255;

   // top level sequencer
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_PREP   = 3'b010,
      ST_DIVIDE = 3'b100
   } state_type;

   // min/max tracker control
   typedef struct packed {
      logic update;
      logic close;
   } obs_cmd_type;

   // divider control
   typedef struct packed {
      logic start;
      logic full_len;
   } div_cmd_type;

endpackage

// ----- sv/mmq_req_if.sv -----
// ----------------------------------------------------------------------------
// mmq_req_if
// Request channel of the quantizer: valid/ready with one sample word.
// ----------------------------------------------------------------------------
interface mmq_req_if #(
   parameter int SAMPLE_WIDTH = 32
);
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           last;

   modport source (output valid, output req_type, output sample, output last, input ready);
   modport sink   (input valid, input req_type, input sample, input last, output ready);
endinterface

// ----- sv/mmq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mmq_rsp_if
// Response channel of the quantizer: valid/ready with a scale or a code word.
// ----------------------------------------------------------------------------
interface mmq_rsp_if #(
   parameter int SCALE_WIDTH = 25
);
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [SCALE_WIDTH-1:0] scale_out;
   logic signed [7:0]      code;

   modport source (output valid, output kind, output scale_out, output code, input ready);
   modport sink   (input valid, input kind, input scale_out, input code, output ready);
endinterface

// ----- sv/min_max_int8_quantizer_unit.sv -----
// ----------------------------------------------------------------------------
// min_max_int8_quantizer_unit
// Per-tensor int8 quantizer: observe pass finds min/max and the scale,
// quantize pass divides each sample by the scale with rounding and clamping.
//
//   channel  dir  handshake     word
//   req_if   in   valid/ready   req_type, sample, last
//   rsp_if   out  valid/ready   kind, scale_out, code
//
// An observe word without last is taken with no result.
// A quantize word reaches a result through operand setup, the divider steps
// for the code quotient bits and the output load; a closing observe word divides
// for every scale bit on the bit-serial divider, which handles one quotient bit a cycle.
// The result sits in an output register, so a new word is taken while it waits;
// a stalled result holds the divider only at the point of the next load.
// Reset is synchronous and gives scale 1.0 and a closed pass.
// ----------------------------------------------------------------------------
module min_max_int8_quantizer_unit import mmq_pkg::*; #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int FRAC_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   mmq_req_if.sink     req_if,
   mmq_rsp_if.source   rsp_if
);

   localparam int SCALE_WIDTH = SAMPLE_WIDTH - 7;
   localparam int DIV_WIDTH   = SAMPLE_WIDTH + 2;
   localparam int OPND_WIDTH  = SAMPLE_WIDTH + 3;
   localparam logic [SCALE_WIDTH-1:0] ONE_FIXED = SCALE_WIDTH'(64'd1 << FRAC_BITS);

   state_type                      state_ff, state_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic                           type_ff, type_in;
   logic [SCALE_WIDTH-1:0]         scale_ff, scale_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_kind_ff, rsp_kind_in;
   logic [SCALE_WIDTH-1:0]         rsp_scale_ff, rsp_scale_in;
   logic [7:0]                     rsp_code_ff, rsp_code_in;

   logic                           req_fire;
   obs_cmd_type                    obs_cmd;
   div_cmd_type                    div_cmd;
   logic [SAMPLE_WIDTH:0]          range_val;
   logic                           range_zero;
   logic [DIV_WIDTH-1:0]           dividend;
   logic [DIV_WIDTH-1:0]           divisor;
   logic                           div_busy;
   logic [SCALE_WIDTH-1:0]         quotient;
   logic [SCALE_WIDTH-1:0]         eff_scale;
   logic signed [OPND_WIDTH-1:0]   twice_sample;
   logic signed [OPND_WIDTH-1:0]   scale_wide;
   logic signed [OPND_WIDTH-1:0]   num_wide;
   logic [QUANT_QUOT_BITS-1:0]     q_mag;
   logic [QUANT_QUOT_BITS-1:0]     q_neg;
   logic [7:0]                     code_val;
   logic [SCALE_WIDTH-1:0]         scale_val;
   logic                           slot_free;

   assign req_fire     = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   // min/max tracking on observe words
   assign obs_cmd.update = req_fire && (req_if.req_type == REQ_OBSERVE);
   assign obs_cmd.close  = req_if.last;

   mmq_range #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_mmq_range (
      .clock      (clock),
      .reset      (reset),
      .cmd        (obs_cmd),
      .sample     (req_if.sample),
      .range_val  (range_val),
      .range_zero (range_zero)
   );

   // divider operands: range/255, or (2|s| + scale) / (2 scale)
   assign eff_scale    = (scale_ff == '0) ? SCALE_WIDTH'(1) : scale_ff;
   assign twice_sample = OPND_WIDTH'($signed({sample_ff, 1'b0}));
   assign scale_wide   = $signed({{(OPND_WIDTH-SCALE_WIDTH){1'b0}}, eff_scale});
   assign num_wide     = sample_ff[SAMPLE_WIDTH-1] ? (scale_wide - twice_sample)
                                                   : (scale_wide + twice_sample);

   always_comb begin
      if (type_ff == REQ_QUANTIZE) begin
         dividend = num_wide[DIV_WIDTH-1:0];
         divisor  = DIV_WIDTH'({eff_scale, 1'b0});
      end else begin
         dividend = DIV_WIDTH'(range_val);
         divisor  = DIV_WIDTH'(RANGE_DIVISOR);
      end
   end

   assign div_cmd.start    = (state_ff == ST_PREP);
   assign div_cmd.full_len = (type_ff == REQ_OBSERVE);

   mmq_serial_div #(
      .DIV_WIDTH  (DIV_WIDTH),
      .QUOT_WIDTH (SCALE_WIDTH)
   ) u_mmq_serial_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // clamp the code magnitude and apply the sign
   always_comb begin
      if (sample_ff[SAMPLE_WIDTH-1]) begin
         q_mag    = (quotient[QUANT_QUOT_BITS-1:0] > CODE_NEG_LIMIT) ? CODE_NEG_LIMIT
                                                                  : quotient[QUANT_QUOT_BITS-1:0];
         q_neg    = '0 - q_mag;
         code_val = q_neg[7:0];
      end else begin
         q_mag    = (quotient[QUANT_QUOT_BITS-1:0] > CODE_POS_LIMIT) ? CODE_POS_LIMIT
                                                                  : quotient[QUANT_QUOT_BITS-1:0];
         q_neg    = '0;
         code_val = q_mag[7:0];
      end
   end

   // scale with the zero-range and one-lsb floor cases
   always_comb begin
      if (range_zero)             scale_val = ONE_FIXED;
      else if (quotient == '0)    scale_val = SCALE_WIDTH'(1);
      else                        scale_val = quotient;
   end

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   // sequencer and output word
   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      type_in      = type_ff;
      scale_in     = scale_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_scale_in = rsp_scale_ff;
      rsp_code_in  = rsp_code_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sample_in = req_if.sample;
               type_in   = req_if.req_type;
               if (req_if.req_type == REQ_QUANTIZE || req_if.last) state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_busy && slot_free) begin
               rsp_valid_in = 1'b1;
               if (type_ff == REQ_QUANTIZE) begin
                  rsp_kind_in  = KIND_CODE;
                  rsp_scale_in = '0;
                  rsp_code_in  = code_val;
               end else begin
                  rsp_kind_in  = KIND_SCALE;
                  rsp_scale_in = scale_val;
                  rsp_code_in  = '0;
                  scale_in     = scale_val;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scale_ff     <= ONE_FIXED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      type_ff      <= type_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_scale_ff <= rsp_scale_in;
      rsp_code_ff  <= rsp_code_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.kind      = rsp_kind_ff;
   assign rsp_if.scale_out = rsp_scale_ff;
   assign rsp_if.code      = rsp_code_ff;

endmodule

// ----- sv/mmq_range.sv -----
// ----------------------------------------------------------------------------
// mmq_range
// Running minimum and maximum of the observe pass, and the range they span.
// ----------------------------------------------------------------------------
module mmq_range import mmq_pkg::*; #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  obs_cmd_type                    cmd,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   output logic        [SAMPLE_WIDTH:0]   range_val,
   output logic                           range_zero
);

   logic signed [SAMPLE_WIDTH-1:0] min_ff, min_in;
   logic signed [SAMPLE_WIDTH-1:0] max_ff, max_in;
   logic                           open_ff, open_in;

   // first sample of a pass starts afresh, later ones widen the bounds
   always_comb begin
      min_in  = min_ff;
      max_in  = max_ff;
      open_in = open_ff;
      if (cmd.update) begin
         if (!open_ff) begin
            min_in = sample;
            max_in = sample;
         end else begin
            if (sample < min_ff) min_in = sample;
            if (sample > max_ff) max_in = sample;
         end
         open_in = !cmd.close;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= '0;
         max_ff  <= '0;
         open_ff <= 1'b0;
      end else begin
         min_ff  <= min_in;
         max_ff  <= max_in;
         open_ff <= open_in;
      end
   end

   // range is never negative since max never drops below min
   assign range_val  = {max_ff[SAMPLE_WIDTH-1], max_ff} - {min_ff[SAMPLE_WIDTH-1], min_ff};
   assign range_zero = (max_ff == min_ff);

endmodule

// ----- sv/mmq_serial_div.sv -----
// ----------------------------------------------------------------------------
// mmq_serial_div
// Restoring divider, one quotient bit per cycle, shared by scale and code.
// ----------------------------------------------------------------------------
module mmq_serial_div import mmq_pkg::*; #(
   parameter int DIV_WIDTH  = 34,
   parameter int QUOT_WIDTH = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  div_cmd_type           cmd,
   input  logic [DIV_WIDTH-1:0]  dividend,
   input  logic [DIV_WIDTH-1:0]  divisor,
   output logic                  busy,
   output logic [QUOT_WIDTH-1:0] quotient
);

   localparam int CNT_WIDTH = $clog2(QUOT_WIDTH + 1);

   logic [DIV_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]  dvs_ff, dvs_in;
   logic [QUOT_WIDTH-1:0] quo_ff, quo_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [DIV_WIDTH:0]    diff;
   logic                  fits;

   // trial subtract of the aligned divisor
   assign diff = {1'b0, rem_ff} - {1'b0, dvs_ff};
   assign fits = !diff[DIV_WIDTH];

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (cmd.start) begin
         // align divisor with the top quotient bit of the chosen length
         rem_in  = dividend;
         quo_in  = '0;
         busy_in = 1'b1;
         if (cmd.full_len) begin
            dvs_in = divisor << (QUOT_WIDTH - 1);
            cnt_in = CNT_WIDTH'(QUOT_WIDTH);
         end else begin
            dvs_in = divisor << (QUANT_QUOT_BITS - 1);
            cnt_in = CNT_WIDTH'(QUANT_QUOT_BITS);
         end
      end else if (busy_ff) begin
         if (fits) rem_in = diff[DIV_WIDTH-1:0];
         quo_in  = {quo_ff[QUOT_WIDTH-2:0], fits};
         dvs_in  = dvs_ff >> 1;
         cnt_in  = cnt_ff - CNT_WIDTH'(1);
         busy_in = (cnt_ff != CNT_WIDTH'(1));
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/mmq_checker.sv -----
// ----------------------------------------------------------------------------
// mmq_checker
// Port-level checks of the quantizer, bound to the top level.
// ----------------------------------------------------------------------------
module mmq_checker import mmq_pkg::*; #(
   parameter int SCALE_WIDTH = 25
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_type,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_kind,
   input logic [SCALE_WIDTH-1:0] rsp_scale_out,
   input logic [7:0]             rsp_code
);

   // reset empties the output register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_scale_out) && $stable(rsp_code))
      else $error("stalled response word changed");

   // the field of the other kind reads as zero
   a_clean_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_CODE && rsp_scale_out == '0)
         || (rsp_kind == KIND_SCALE && rsp_code == '0))
      else $error("unused response field not zero");

   // a code goes through the divider, never out in the next cycle
   a_code_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_QUANTIZE && !rsp_valid |=> !rsp_valid)
      else $error("code response too early");

   // one quantize word at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_QUANTIZE |=> !req_ready)
      else $error("request taken while a division runs");

endmodule

bind min_max_int8_quantizer_unit mmq_checker #(
   .SCALE_WIDTH (SAMPLE_WIDTH - 7)
) u_mmq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_type      (req_if.req_type),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_kind      (rsp_if.kind),
   .rsp_scale_out (rsp_if.scale_out),
   .rsp_code      (rsp_if.code)
);
